### rtl/dotted_quad_split_enumerator_macros.svh
// Assertion macros for the dotted-quad split enumerator.
// Included by files that carry concurrent checks; needs nothing else.
`ifndef DOTTED_QUAD_SPLIT_ENUMERATOR_MACROS_SVH
`define DOTTED_QUAD_SPLIT_ENUMERATOR_MACROS_SVH

// Clocked check with explicit clock and active-low reset
`define DQSE_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on the block's own clock and reset
`define DQSE_ASSERT(label, prop, msg) \
  `DQSE_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### rtl/dqse_pkg.sv
// Shared types and constants for the dotted-quad split enumerator.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package dqse_pkg;

  // Segment rules
  localparam int unsigned SEG_MAX_LEN = 3;
  localparam int unsigned MIN_DIGITS  = 4;
  localparam int unsigned OCTET_MAX   = 255;
  localparam int unsigned DIGIT_MAX   = 9;
  localparam int unsigned NUM_SEGS    = 4;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_GEOM,
    ST_SCAN,
    ST_JUDGE,
    ST_FLUSH
  } dqse_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic store;       // write accepted digit
    logic start_run;   // last digit seen, reset candidate walk
    logic advance;     // step to next (a,b,c) candidate
    logic scan_start;  // begin digit scan for current candidate
    logic scan;        // scan in progress
    logic keep;        // candidate valid, move into hold slot
    logic flush;       // emit final result, clear string state
  } dqse_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip;        // string too short or too long
    logic geom_ok;     // fourth segment length is 1..3
    logic last_cand;   // current candidate is (3,3,3)
    logic scan_done;   // last digit of scan processed
    logic cand_ok;     // scanned candidate passed all checks
    logic held_valid;  // hold slot carries a result
    logic out_free;    // output register can take a result
  } dqse_sts_t;

endpackage

`default_nettype wire

### rtl/dqse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dqse_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/dqse_ctrl.sv
// Sequencing state machine for the dotted-quad split enumerator.
// Depends on dqse_pkg; drives commands to dqse_dp.
`default_nettype none

module dqse_ctrl
  import dqse_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_last_i,
  output logic           in_ready_o,
  input  wire dqse_sts_t sts_i,
  output dqse_cmd_t      cmd_o
);

  dqse_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.store = 1'b1;
          if (in_last_i) begin
            cmd_o.start_run = 1'b1;
            state_d         = ST_GEOM;
          end
        end
      end
      ST_GEOM: begin
        if (sts_i.skip) begin
          state_d = ST_FLUSH;
        end else if (sts_i.geom_ok) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = sts_i.last_cand ? ST_FLUSH : ST_GEOM;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        // a valid candidate displaces the held one, which needs the output
        if (!(sts_i.cand_ok && sts_i.held_valid && !sts_i.out_free)) begin
          cmd_o.keep    = sts_i.cand_ok;
          cmd_o.advance = 1'b1;
          state_d       = sts_i.last_cand ? ST_FLUSH : ST_GEOM;
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/dqse_dp.sv
// Datapath: digit store, candidate counters, segment scan, hold slot, output register.
// Depends on dqse_pkg and dqse_ram; commanded by dqse_ctrl.
`default_nettype none

module dqse_dp
  import dqse_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [3:0]  digit_i,
  input  wire dqse_cmd_t   cmd_i,
  output dqse_sts_t        sts_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      out_octets_o,
  output logic             out_found_o,
  output logic             out_last_o
);

  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned AW = $clog2(MAX_DIGITS);

  // String state
  logic [CW-1:0] count_q;
  logic          too_long_q;
  // Candidate segment lengths, each 1..3
  logic [1:0]    a_q, b_q, c_q;
  // Scan state
  logic [CW-1:0] pos_q, rpos_q;
  logic          rd_v_q;
  logic [9:0]    acc_q;
  logic          lz_q, bad_q;
  logic [7:0]    oct_q [NUM_SEGS];
  // Hold slot and output register
  logic          held_valid_q;
  logic [31:0]   held_q;
  logic          out_valid_q, out_found_q, out_last_q;
  logic [31:0]   out_octets_q;

  logic [3:0]    rdata;
  logic          store_en, issue;
  logic [CW-1:0] b1, b2, b3, used, rpos_nx;
  logic          seg_start, seg_end;
  logic [1:0]    seg_idx;
  logic [9:0]    acc_base, acc_new;
  logic          bad_new, lz_new;
  logic          push;

  assign store_en = cmd_i.store && (count_q < CW'(MAX_DIGITS));
  assign issue    = cmd_i.scan && (pos_q < count_q);

  dqse_ram #(
    .WIDTH (4),
    .DEPTH (MAX_DIGITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (digit_i),
    .raddr_i (pos_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Segment boundaries of the current candidate
  assign b1      = CW'(a_q);
  assign b2      = b1 + CW'(b_q);
  assign b3      = b2 + CW'(c_q);
  assign used    = b3;
  assign rpos_nx = rpos_q + CW'(1);

  // Per-digit segment evaluation
  always_comb begin
    seg_start = (rpos_q == '0) || (rpos_q == b1) || (rpos_q == b2) || (rpos_q == b3);
    seg_end   = (rpos_nx == b1) || (rpos_nx == b2) || (rpos_nx == b3) ||
                (rpos_nx == count_q);
    if (rpos_q < b1) begin
      seg_idx = 2'd0;
    end else if (rpos_q < b2) begin
      seg_idx = 2'd1;
    end else if (rpos_q < b3) begin
      seg_idx = 2'd2;
    end else begin
      seg_idx = 2'd3;
    end
    acc_base = seg_start ? '0 : acc_q;
    acc_new  = (acc_base << 3) + (acc_base << 1) + 10'(rdata);
    lz_new   = seg_start ? (rdata == 4'd0) : lz_q;
    bad_new  = bad_q || (rdata > 4'(DIGIT_MAX)) || (!seg_start && lz_q) ||
               (seg_end && (acc_new > 10'(OCTET_MAX)));
  end

  // Status to controller
  always_comb begin
    sts_o            = '0;
    sts_o.skip       = too_long_q || (count_q < CW'(MIN_DIGITS));
    sts_o.geom_ok    = (used < count_q) && ((count_q - used) <= CW'(SEG_MAX_LEN));
    sts_o.last_cand  = (a_q == 2'(SEG_MAX_LEN)) && (b_q == 2'(SEG_MAX_LEN)) &&
                       (c_q == 2'(SEG_MAX_LEN));
    sts_o.scan_done  = rd_v_q && (rpos_nx == count_q);
    sts_o.cand_ok    = !bad_q;
    sts_o.held_valid = held_valid_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Digit count and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      too_long_q <= 1'b0;
    end else if (cmd_i.flush) begin
      count_q    <= '0;
      too_long_q <= 1'b0;
    end else if (cmd_i.store) begin
      if (store_en) begin
        count_q <= count_q + CW'(1);
      end else begin
        too_long_q <= 1'b1;
      end
    end
  end

  // Candidate walk in backtracking order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 2'd1;
      b_q <= 2'd1;
      c_q <= 2'd1;
    end else if (cmd_i.start_run) begin
      a_q <= 2'd1;
      b_q <= 2'd1;
      c_q <= 2'd1;
    end else if (cmd_i.advance) begin
      if (c_q == 2'(SEG_MAX_LEN)) begin
        c_q <= 2'd1;
        if (b_q == 2'(SEG_MAX_LEN)) begin
          b_q <= 2'd1;
          a_q <= a_q + 2'd1;
        end else begin
          b_q <= b_q + 2'd1;
        end
      end else begin
        c_q <= c_q + 2'd1;
      end
    end
  end

  // Scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      rpos_q <= '0;
      rd_v_q <= 1'b0;
      bad_q  <= 1'b0;
    end else if (cmd_i.scan_start) begin
      pos_q  <= '0;
      rd_v_q <= 1'b0;
      bad_q  <= 1'b0;
    end else if (cmd_i.scan) begin
      rd_v_q <= issue;
      rpos_q <= pos_q;
      if (issue) begin
        pos_q <= pos_q + CW'(1);
      end
      if (rd_v_q) begin
        bad_q <= bad_new;
      end
    end
  end

  // Segment accumulator and octet capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && rd_v_q) begin
      acc_q <= acc_new;
      lz_q  <= lz_new;
      if (seg_end) begin
        oct_q[seg_idx] <= acc_new[7:0];
      end
    end
  end

  assign push = (cmd_i.keep && held_valid_q) || cmd_i.flush;

  // Hold slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
    end else if (cmd_i.start_run || cmd_i.flush) begin
      held_valid_q <= 1'b0;
    end else if (cmd_i.keep) begin
      held_valid_q <= 1'b1;
    end
  end

  // Hold slot payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.keep) begin
      held_q <= {oct_q[3], oct_q[2], oct_q[1], oct_q[0]};
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      out_octets_q <= held_valid_q ? held_q : '0;
      out_found_q  <= held_valid_q;
      out_last_q   <= cmd_i.flush;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_octets_o = out_octets_q;
  assign out_found_o  = out_found_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

### rtl/dotted_quad_split_enumerator.sv
// Dotted-quad split enumerator:
// Slave stream takes one decimal digit per transaction; tlast marks the
// final digit of a string. Up to 12 digits are kept in a small RAM.
// After the final digit the block walks all 27 (a,b,c) segment-length
// candidates in backtracking order and sends every valid address split as
// one master-stream transaction: four octets in tdata, tuser = found,
// tlast on the final result of the string. With no valid split, or a
// string shorter than 4 or longer than 12 digits, one transaction with
// found clear and zero octets is sent.
// Timing: digits load at one per cycle until the final digit. After it each
// candidate gets a length check; a candidate whose last segment fits is
// then scanned through the single read port of the digit RAM, which
// delivers one digit per cycle. A short or overlong string skips the walk
// and goes straight to the flush; otherwise the whole walk, with at most 19
// scanned candidates (eight digits), runs before the next digit is taken.
// Reset clears the controller, the digit count and the output register.
// A stalled master side holds the result; the search pauses until the
// output register frees, so no result is lost.
`default_nettype none

`include "dotted_quad_split_enumerator_macros.svh"

module dotted_quad_split_enumerator
  import dqse_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [3:0] digit, [7:4] zero
  input  wire logic        s_axis_tlast,   // final_digit
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // octet_a, octet_b, octet_c, octet_d
  output logic             m_axis_tuser,   // found
  output logic             m_axis_tlast    // last_result
);

  dqse_cmd_t ctl_cmd;
  dqse_sts_t dp_sts;

  dqse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (ctl_cmd)
  );

  dqse_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .digit_i      (s_axis_tdata[3:0]),
    .cmd_i        (ctl_cmd),
    .sts_o        (dp_sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_octets_o (m_axis_tdata),
    .out_found_o  (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  // Checks on controller and datapath cooperation
  `DQSE_ASSERT(a_flush_free, ctl_cmd.flush |-> dp_sts.out_free, "flush with output busy")
  `DQSE_ASSERT(a_scan_geom, ctl_cmd.scan_start |-> (dp_sts.geom_ok && !dp_sts.skip), "bad scan")
  `DQSE_ASSERT(a_keep_ok, ctl_cmd.keep |-> dp_sts.cand_ok, "kept a failed candidate")
  `DQSE_ASSERT(a_miss_last, (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast, "miss not last")

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking bench for dotted_quad_split_enumerator: digit strings go in on the
// slave stream and each address split that comes out is compared with an in-bench predictor.
// Depends on the RTL top level and dqse_pkg for the segment constants.
module tb;
  import dqse_pkg::*;

  localparam int DIGIT_CAP   = 12;   // digits the block keeps per string
  localparam int SPLIT_CAP   = 19;   // most splits one string can yield
  localparam int N_DIRECTED  = 5;
  localparam int DRAIN_WAIT  = 200;  // cycles after the last result
  localparam int RX_HOLD_LEN = 400;  // receiver hold-off, in cycles

  // One address split as seen on the master stream
  typedef struct packed {
    logic [7:0] oct_a;
    logic [7:0] oct_b;
    logic [7:0] oct_c;
    logic [7:0] oct_d;
    logic       found;
    logic       last_res;
  } addr_split_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [3:0] digit, [7:4] zero
  logic        s_axis_tlast = 1'b0;    // final_digit
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // octet_a, octet_b, octet_c, octet_d
  logic        m_axis_tuser;           // found
  logic        m_axis_tlast;           // last_result

  // Predictor state
  logic [3:0]  digit_mem [DIGIT_CAP];
  int          digit_cnt = 0;
  bit          overflow = 1'b0;
  addr_split_t split_q [$];

  // Run control and bookkeeping
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  rx_hold = 1'b0;
  bit  hold_go = 1'b0;
  int  mismatches = 0;
  int  digits_sent = 0;
  int  strings_sent = 0;
  int  splits_seen = 0;
  int  found_seen = 0;

  // Directed strings; hex letters stand for digit values above nine
  string       dir_text  [N_DIRECTED] = '{"0000", "9", "255255255255", "10F1", "010010"};
  bit          dir_typed [N_DIRECTED] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
  addr_split_t dir_want  [N_DIRECTED] = '{
    '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1},
    '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1},
    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1},
    '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1},
    '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0}
  };

  dotted_quad_split_enumerator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Segment value, or -1 when the segment is not a legal octet
  function automatic int octet_of(int pos, int len);
    int v;
    int k;
    v = 0;
    if (len < 1 || len > SEG_MAX_LEN || pos + len > digit_cnt) return -1;
    if (len > 1 && digit_mem[pos] == 4'd0) return -1;
    for (k = 0; k < len; k++) begin
      if (digit_mem[pos + k] > DIGIT_MAX) return -1;
      v = v * 10 + digit_mem[pos + k];
    end
    if (v > OCTET_MAX) return -1;
    return v;
  endfunction

  // Take one accepted digit; on the final digit list every legal split
  task automatic absorb_digit(input logic [3:0] d, input bit fin, ref addr_split_t res[$]);
    int a, b, c, used;
    int oa, ob, oc, od;
    res.delete();
    if (digit_cnt < DIGIT_CAP) begin
      digit_mem[digit_cnt] = d;
      digit_cnt++;
    end else begin
      overflow = 1'b1;
    end
    if (!fin) return;
    if (!overflow && digit_cnt >= MIN_DIGITS) begin
      for (a = 1; a <= SEG_MAX_LEN; a++) begin
        oa = octet_of(0, a);
        if (oa < 0) continue;
        for (b = 1; b <= SEG_MAX_LEN; b++) begin
          ob = octet_of(a, b);
          if (ob < 0) continue;
          for (c = 1; c <= SEG_MAX_LEN; c++) begin
            used = a + b + c;
            oc = octet_of(a + b, c);
            if (oc < 0 || used >= digit_cnt) continue;
            od = octet_of(used, digit_cnt - used);
            if (od < 0) continue;
            if (res.size() < SPLIT_CAP)
              res.push_back('{oa[7:0], ob[7:0], oc[7:0], od[7:0], 1'b1, 1'b0});
          end
        end
      end
    end
    if (res.size() == 0)
      res.push_back('{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0});
    res[res.size() - 1].last_res = 1'b1;
    digit_cnt = 0;
    overflow = 1'b0;
  endtask

  // Offer one digit and wait for its transaction
  task automatic offer_digit(input logic [3:0] d, input bit fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, d};
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    digits_sent++;
  endtask

  // Send a whole string; a typed expectation replaces the predicted one
  task automatic send_string(input logic [3:0] ds[$], input bit typed, input addr_split_t want);
    addr_split_t res [$];
    int i;
    for (i = 0; i < ds.size(); i++) begin
      offer_digit(ds[i], i == ds.size() - 1);
      absorb_digit(ds[i], i == ds.size() - 1, res);
    end
    if (typed) split_q.push_back(want);
    else foreach (res[j]) split_q.push_back(res[j]);
    strings_sent++;
  endtask

  // Random string: half built from real octets, the rest raw, short or overlong
  task automatic make_string(ref logic [3:0] ds[$]);
    int kind, len, v, s, i;
    ds.delete();
    kind = $urandom_range(99);
    if (kind < 50) begin
      for (s = 0; s < 4; s++) begin
        case ($urandom_range(3))
          0:       v = $urandom_range(9);
          1:       v = $urandom_range(99);
          2:       v = $urandom_range(255);
          default: v = 200 + $urandom_range(55);
        endcase
        if (v >= 100) ds.push_back(4'(v / 100));
        if (v >= 10) ds.push_back(4'((v / 10) % 10));
        ds.push_back(4'(v % 10));
      end
    end else begin
      if (kind < 80)      len = $urandom_range(12, 4);
      else if (kind < 90) len = $urandom_range(3, 1);
      else                len = $urandom_range(15, 13);
      for (i = 0; i < len; i++)
        ds.push_back(4'($urandom_range(99) < 60 ? $urandom_range(2) : $urandom_range(9)));
    end
    // occasional digit values above nine
    foreach (ds[j])
      if ($urandom_range(99) < 3) ds[j] = 4'($urandom_range(15, 10));
  endtask

  task automatic random_strings(input int digit_target);
    logic [3:0] ds [$];
    while (digits_sent < digit_target) begin
      make_string(ds);
      send_string(ds, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls plus the long hold-off
  always @(posedge clk_i)
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);

  initial begin : rx_hold_ctl
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_LEN) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic note_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
  endtask

  // Compare each result transaction with the oldest expected split
  always @(posedge clk_i) begin : split_check
    addr_split_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      splits_seen++;
      if (m_axis_tuser === 1'b1) found_seen++;
      if (split_q.size() == 0) begin
        note_mismatch("unexpected result, octets", 32'd0, m_axis_tdata);
      end else begin
        want = split_q.pop_front();
        if (m_axis_tdata[7:0] !== want.oct_a)
          note_mismatch("octet_a", 32'(want.oct_a), 32'(m_axis_tdata[7:0]));
        if (m_axis_tdata[15:8] !== want.oct_b)
          note_mismatch("octet_b", 32'(want.oct_b), 32'(m_axis_tdata[15:8]));
        if (m_axis_tdata[23:16] !== want.oct_c)
          note_mismatch("octet_c", 32'(want.oct_c), 32'(m_axis_tdata[23:16]));
        if (m_axis_tdata[31:24] !== want.oct_d)
          note_mismatch("octet_d", 32'(want.oct_d), 32'(m_axis_tdata[31:24]));
        if (m_axis_tuser !== want.found)
          note_mismatch("found", 32'(want.found), 32'(m_axis_tuser));
        if (m_axis_tlast !== want.last_res)
          note_mismatch("last_result", 32'(want.last_res), 32'(m_axis_tlast));
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d results outstanding", split_q.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin : main
    logic [3:0] ds [$];
    int r, i, d;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender sparse, receiver mostly stalled
    send_idle_pct = 38;
    recv_idle_pct = 88;
    for (r = 0; r < N_DIRECTED; r++) begin
      ds.delete();
      for (i = 0; i < dir_text[r].len(); i++) begin
        d = dir_text[r][i];
        ds.push_back(4'(d <= "9" ? d - "0" : d - "A" + 10));
      end
      send_string(ds, dir_typed[r], dir_want[r]);
    end
    random_strings(140);

    // Sender mostly idle, receiver eager
    send_idle_pct = 88;
    recv_idle_pct = 38;
    random_strings(260);

    // Full rate, with one long receiver hold-off at the start
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b1;
    random_strings(370);

    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    while (split_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d digits in %0d strings; checked %0d results, %0d with an address found",
             digits_sent, strings_sent, splits_seen, found_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching fields", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### dotted_quad_split_enumerator.f
+incdir+rtl
rtl/dqse_pkg.sv
rtl/dqse_ram.sv
rtl/dqse_ctrl.sv
rtl/dqse_dp.sv
rtl/dotted_quad_split_enumerator.sv
tb/tb.sv
